// ===== rtl/heat_diffusion_stencil_2d_macros.svh =====
// Assertion macros shared by the verification code of the heat diffusion stencil.
// No dependencies; included by the checker file.
`ifndef HEAT_DIFFUSION_STENCIL_2D_MACROS_SVH
`define HEAT_DIFFUSION_STENCIL_2D_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HDS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define HDS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/hds_pkg.sv =====
// Package of the heat diffusion stencil: fixed widths, register indexes and
// arithmetic constants. No dependencies.
package hds_pkg;

    localparam int COEF_W     = 16;
    localparam int CFG_ADDR_W = 2;
    localparam int FRAC_W     = 16;
    localparam int ROUND_HALF = 32768;

    typedef logic [COEF_W-1:0]     coef_t;
    typedef logic [CFG_ADDR_W-1:0] cfg_addr_t;

    localparam cfg_addr_t REG_COEF_X = 2'd0;
    localparam cfg_addr_t REG_COEF_Y = 2'd1;

    localparam coef_t COEF_RESET = 16'd655;

    // Per-result control that rides along the arithmetic stages.
    typedef struct packed {
        logic interior;  // cell is not on the grid border
        logic pair;      // cell lies on the second to last row: a border result follows
        logic fend;      // the following border result is the last cell of the grid
    } stage_flags_t;

endpackage

// ===== rtl/heat_diffusion_stencil_2d.sv =====
// Top level of the five-point explicit heat diffusion stencil with its row memory.
// Depends on hds_pkg.
//
//   Channel   Direction  Signals                               Payload
//   s_*       in         s_tvalid s_tready s_tdata s_tuser     sample, frame_start
//   m_*       out        m_tvalid m_tready m_tdata m_tlast     new_temperature, last,
//                        m_tuser                               frame_end
//   cfg_*     in         cfg_we cfg_addr cfg_wdata             coef_x (0), coef_y (1)
//
// One sample is taken per clock cycle while the output is not stalled. A sample of
// the last grid row causes two results, so on that row the single output register
// holds the input until both results have left. A result passes from the transfer
// through memory read, difference, multiply, and round and saturate registers.
// Reset is asynchronous and clears position and pipeline valid bits and loads the
// coefficient reset value; the row memory is not cleared and needs no sweep, since
// an entry is written before any interior cell reads it. When m_tready is low the
// pipeline fills and then s_tready drops; no result is lost.
module heat_diffusion_stencil_2d #(
    parameter int GRID_SIZE    = 256,
    parameter int SAMPLE_WIDTH = 24,
    localparam int DATA_W      = ((SAMPLE_WIDTH + 7) / 8) * 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    // Input stream.
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [DATA_W-1:0]     s_tdata,   // sample
    input  logic                  s_tuser,   // frame_start
    // Output stream.
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [DATA_W-1:0]     m_tdata,   // new_temperature
    output logic                  m_tlast,
    output logic                  m_tuser,   // frame_end
    // Configuration writes.
    input  logic                  cfg_we,
    input  hds_pkg::cfg_addr_t    cfg_addr,
    input  hds_pkg::coef_t        cfg_wdata
);

    import hds_pkg::*;

    localparam int CW   = $clog2(GRID_SIZE);
    localparam int SW   = SAMPLE_WIDTH;
    localparam int DW   = SW + 2;           // width of a second difference
    localparam int CXW  = COEF_W + 1;       // coefficient as a signed operand
    localparam int PW   = DW + CXW;         // product width
    localparam int SUMW = PW + 2;           // sum of two products and the centre
    localparam int QW   = SUMW - FRAC_W;    // rounded sum before saturation

    localparam logic [CW-1:0] LAST_IDX = CW'(GRID_SIZE - 1);
    localparam logic [CW-1:0] ROW_TWO  = CW'(2);

    typedef logic signed [SW-1:0] sample_t;

    // One memory entry holds both stored rows of a column.
    typedef struct packed {
        sample_t upper;
        sample_t middle;
    } row_entry_t;

    localparam sample_t SAMPLE_MAX = {1'b0, {(SW-1){1'b1}}};
    localparam sample_t SAMPLE_MIN = {1'b1, {(SW-1){1'b0}}};

    // Configuration registers.
    coef_t coef_x_reg;
    coef_t coef_y_reg;

    // Position of the next sample in the grid.
    logic [CW-1:0] col_reg;
    logic [CW-1:0] row_reg;
    logic [CW-1:0] col_cur;
    logic [CW-1:0] row_cur;
    logic [CW-1:0] col_next;
    logic [CW-1:0] row_next;
    logic          col_wrap;

    // Row memory and its registered read data.
    row_entry_t row_mem [GRID_SIZE];
    row_entry_t rd_reg;

    // Centre of the previous stencil, which is the left neighbor of the next one.
    sample_t win_centre_reg;

    sample_t      sample_in;
    logic         accept;
    logic         ready2;
    logic         ready3;
    logic         out_free;
    stage_flags_t flags_in;

    // Stage 1: neighbors gathered at the transfer.
    logic         s1_valid_reg;
    sample_t      s1_left_reg;
    sample_t      s1_centre_reg;
    sample_t      s1_up_reg;
    sample_t      s1_down_reg;
    stage_flags_t s1_flags_reg;

    // Stage 2: second differences.
    logic              s2_valid_reg;
    logic signed [DW-1:0] s2_dxx_reg;
    logic signed [DW-1:0] s2_dyy_reg;
    sample_t           s2_centre_reg;
    stage_flags_t      s2_flags_reg;
    logic signed [DW-1:0] dxx_next;
    logic signed [DW-1:0] dyy_next;

    // Stage 3: products.
    logic              s3_valid_reg;
    logic signed [PW-1:0] s3_px_reg;
    logic signed [PW-1:0] s3_py_reg;
    sample_t           s3_centre_reg;
    stage_flags_t      s3_flags_reg;
    logic signed [PW-1:0] px_next;
    logic signed [PW-1:0] py_next;

    // Output register; the phase bit marks the border result of a pair.
    logic              out_valid_reg;
    logic              out_phase_reg;
    sample_t           out_value_reg;
    logic              out_pair_reg;
    logic              out_fend_reg;
    logic signed [SUMW-1:0] sum_next;
    logic signed [QW-1:0]   q_next;
    logic              q_fits;
    sample_t           value_next;
    sample_t           out_data;

    assign sample_in = s_tdata[SW-1:0];
    assign accept    = s_tvalid && s_tready;

    // A frame start puts this sample at the grid origin.
    assign col_cur  = s_tuser ? '0 : col_reg;
    assign row_cur  = s_tuser ? '0 : row_reg;
    assign col_wrap = (col_cur == LAST_IDX);
    assign col_next = col_wrap ? '0 : col_cur + 1'b1;
    always_comb
    begin
        row_next = row_cur;
        if (col_wrap)
        begin
            row_next = (row_cur == LAST_IDX) ? '0 : row_cur + 1'b1;
        end
    end

    assign flags_in.interior = (row_cur >= ROW_TWO) && (col_cur != '0) &&
                               (col_cur != LAST_IDX);
    assign flags_in.pair     = (row_cur == LAST_IDX);
    assign flags_in.fend     = (col_cur == LAST_IDX);

    // Backpressure runs from the output register toward the input.
    assign out_free = !out_valid_reg || (m_tready && m_tlast);
    assign ready3   = !s3_valid_reg || out_free;
    assign ready2   = !s2_valid_reg || ready3;
    assign s_tready = !s1_valid_reg || ready2;

    // The memory is read one column ahead: the entry read at this transfer gives
    // the right neighbor of this cell and the centre and upper sample of the next.
    // The column written now was read at the previous transfer, and the column read now
    // was last written a full row ago, so the two ports never touch the same entry
    // at once. Only a frame start breaks that order, and then the grid is on
    // its first row, whose stored values are never used.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            row_mem[col_cur] <= {rd_reg.middle, sample_in};
            rd_reg           <= row_mem[col_next];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_x_reg <= COEF_RESET;
            coef_y_reg <= COEF_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_COEF_X: coef_x_reg <= cfg_wdata;
                REG_COEF_Y: coef_y_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg        <= '0;
            row_reg        <= '0;
            win_centre_reg <= '0;
            s1_valid_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
            s3_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_phase_reg  <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                col_reg        <= col_next;
                row_reg        <= row_next;
                win_centre_reg <= rd_reg.middle;
                // The first row of a grid is only stored.
                s1_valid_reg   <= (row_cur != '0);
            end
            else if (ready2)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (ready2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (ready3)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (out_free)
            begin
                out_valid_reg <= s3_valid_reg;
                out_phase_reg <= 1'b0;
            end
            else if (m_tready)
            begin
                out_phase_reg <= 1'b1;
            end
        end
    end

    // Arithmetic between the stages.
    assign dxx_next = DW'(s1_left_reg) + DW'(rd_reg.middle) - (DW'(s1_centre_reg) <<< 1);
    assign dyy_next = DW'(s1_up_reg) + DW'(s1_down_reg) - (DW'(s1_centre_reg) <<< 1);

    assign px_next = PW'($signed({1'b0, coef_x_reg})) * PW'(s2_dxx_reg);
    assign py_next = PW'($signed({1'b0, coef_y_reg})) * PW'(s2_dyy_reg);

    // Round to nearest with ties upward, then saturate to the sample range.
    assign sum_next = SUMW'(s3_px_reg) + SUMW'(s3_py_reg) +
                      (SUMW'(s3_centre_reg) <<< FRAC_W) + SUMW'(ROUND_HALF);
    assign q_next   = sum_next[SUMW-1:FRAC_W];
    assign q_fits   = (&q_next[QW-1:SW-1]) || !(|q_next[QW-1:SW-1]);
    always_comb
    begin
        value_next = '0;
        if (s3_flags_reg.interior)
        begin
            if (q_fits)
            begin
                value_next = q_next[SW-1:0];
            end
            else
            begin
                value_next = q_next[QW-1] ? SAMPLE_MIN : SAMPLE_MAX;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_left_reg   <= win_centre_reg;
            s1_centre_reg <= rd_reg.middle;
            s1_up_reg     <= rd_reg.upper;
            s1_down_reg   <= sample_in;
            s1_flags_reg  <= flags_in;
        end
        if (ready2)
        begin
            s2_dxx_reg    <= dxx_next;
            s2_dyy_reg    <= dyy_next;
            s2_centre_reg <= s1_centre_reg;
            s2_flags_reg  <= s1_flags_reg;
        end
        if (ready3)
        begin
            s3_px_reg     <= px_next;
            s3_py_reg     <= py_next;
            s3_centre_reg <= s2_centre_reg;
            s3_flags_reg  <= s2_flags_reg;
        end
        if (out_free)
        begin
            out_value_reg <= value_next;
            out_pair_reg  <= s3_flags_reg.pair;
            out_fend_reg  <= s3_flags_reg.fend;
        end
    end

    // The second result of a pair is the zero border cell below.
    assign out_data = out_phase_reg ? '0 : out_value_reg;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = DATA_W'($unsigned(out_data));
    assign m_tlast  = !out_pair_reg || out_phase_reg;
    assign m_tuser  = out_phase_reg && out_fend_reg;

endmodule

// ===== rtl/hds_checker.sv =====
// Port-level checker for the heat diffusion stencil and its bind to the top level.
// Depends on heat_diffusion_stencil_2d_macros.svh.
`include "heat_diffusion_stencil_2d_macros.svh"

module hds_checker #(
    parameter int DATA_W = 24
) (
    input logic              clk,
    input logic              rst_n,
    input logic              m_tvalid,
    input logic              m_tready,
    input logic [DATA_W-1:0] m_tdata,
    input logic              m_tlast,
    input logic              m_tuser
);

    // A stalled result holds its value.
    `HDS_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "output changed while stalled")

    // The last cell of a grid closes the result run of its sample.
    `HDS_ASSERT_SAME(a_fend_last, clk, rst_n, m_tvalid && m_tuser, m_tlast, "frame end without last")

    // The last cell of a grid is a border cell and reads zero.
    `HDS_ASSERT_SAME(a_fend_zero, clk, rst_n, m_tvalid && m_tuser, m_tdata == '0, "frame end cell not zero")

    // A result that is not last is followed at once by the zero border result.
    `HDS_ASSERT_NEXT(a_pair_follow, clk, rst_n, m_tvalid && m_tready && !m_tlast, m_tvalid && m_tlast && (m_tdata == '0), "border result of a pair missing")

endmodule

bind heat_diffusion_stencil_2d hds_checker #(
    .DATA_W (DATA_W)
) u_hds_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);
